/* hdl/dmit_pkg.sv */
// Shared types and constants for the drive motor idle timer.
package dmit_pkg;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_MOTOR_REQ = 3'd1,
    OP_XFER_DONE = 3'd2,
    OP_MOTOR_OFF = 3'd3,
    OP_CTRL_RST  = 3'd4
  } op_t;

  localparam int unsigned CFG_IDX_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STAY_ON_TICKS = 8'd0,
    CFG_COAST_TICKS   = 8'd1,
    CFG_SPIN_UP_TICKS = 8'd2,
    CFG_SKIP_DELAYS   = 8'd3
  } cfg_idx_t;

  localparam int unsigned TICK_W   = 16;
  localparam int unsigned CFG_DATA_W = 16;

  // spin-up wait is divided by four when the same drive still coasts
  localparam int unsigned COAST_DIV_SHIFT = 2;

  localparam logic [TICK_W-1:0] STAY_ON_RST = 16'd2000;
  localparam logic [TICK_W-1:0] COAST_RST   = 16'd1000;
  localparam logic [TICK_W-1:0] SPIN_UP_RST = 16'd500;
  localparam logic [TICK_W-1:0] TICK_MAX    = 16'hFFFF;

  typedef struct packed {
    logic [TICK_W-1:0] stay_on_ticks;
    logic [TICK_W-1:0] coast_ticks;
    logic [TICK_W-1:0] spin_up_ticks;
    logic              skip_delays;
  } cfg_t;

  typedef struct packed {
    logic              motor_running;
    logic              motor_drive;
    logic [TICK_W-1:0] countdown;
    logic [TICK_W-1:0] off_elapsed;
  } state_t;

  typedef struct packed {
    logic [2:0]        operation;
    logic              drive;
    logic [TICK_W-1:0] elapsed_ticks;
  } item_t;

  typedef struct packed {
    logic              motor_a_on;
    logic              motor_b_on;
    logic              selected_drive;
    logic [TICK_W-1:0] spin_wait_ticks;
    logic              running;
  } result_t;

endpackage

/* hdl/dmit_in_if.sv */
// Request channel interface for motor events.
interface dmit_in_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  operation;
  logic                        drive;
  logic [dmit_pkg::TICK_W-1:0] elapsed_ticks;

  modport source (output valid, operation, drive, elapsed_ticks, input ready);
  modport sink   (input valid, operation, drive, elapsed_ticks, output ready);
endinterface

/* hdl/dmit_out_if.sv */
// Result channel interface for motor status.
interface dmit_out_if;
  logic                        valid;
  logic                        ready;
  logic                        motor_a_on;
  logic                        motor_b_on;
  logic                        selected_drive;
  logic [dmit_pkg::TICK_W-1:0] spin_wait_ticks;
  logic                        running;

  modport source (output valid, motor_a_on, motor_b_on, selected_drive,
                  spin_wait_ticks, running, input ready);
  modport sink   (input valid, motor_a_on, motor_b_on, selected_drive,
                  spin_wait_ticks, running, output ready);
endinterface

/* hdl/dmit_cfg_if.sv */
// Configuration write channel interface.
interface dmit_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dmit_pkg::CFG_IDX_W-1:0]  index;
  logic [dmit_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/dmit_step.sv */
// Next-state and result logic for one motor event.
module dmit_step (
  input  dmit_pkg::cfg_t    cfg,
  input  dmit_pkg::state_t  st,
  input  dmit_pkg::item_t   item,
  output dmit_pkg::state_t  st_nxt,
  output dmit_pkg::result_t res
);

  logic [dmit_pkg::TICK_W:0]   sum;
  logic [dmit_pkg::TICK_W-1:0] wait_ticks;
  logic                        coasting;

  assign sum      = {1'b0, st.off_elapsed} + {1'b0, item.elapsed_ticks};
  assign coasting = (st.off_elapsed < cfg.coast_ticks);

  always_comb begin
    st_nxt     = st;
    wait_ticks = '0;
    unique case (item.operation)
      dmit_pkg::OP_TICK: begin
        if (!st.motor_running) begin
          if (coasting) begin
            st_nxt.off_elapsed = sum[dmit_pkg::TICK_W] ? dmit_pkg::TICK_MAX
                                                       : sum[dmit_pkg::TICK_W-1:0];
          end
        end else if (item.elapsed_ticks >= st.countdown) begin
          st_nxt.motor_running = 1'b0;
          st_nxt.off_elapsed   = '0;
          st_nxt.countdown     = '0;
        end else begin
          st_nxt.countdown = st.countdown - item.elapsed_ticks;
        end
      end
      dmit_pkg::OP_MOTOR_REQ: begin
        if (!st.motor_running || (st.motor_drive != item.drive)) begin
          if (!cfg.skip_delays) begin
            if (coasting && (st.motor_drive == item.drive)) begin
              wait_ticks = cfg.spin_up_ticks >> dmit_pkg::COAST_DIV_SHIFT;
            end else begin
              wait_ticks = cfg.spin_up_ticks;
            end
          end
          st_nxt.motor_running = 1'b1;
          st_nxt.motor_drive   = item.drive;
        end
      end
      dmit_pkg::OP_XFER_DONE: begin
        st_nxt.countdown = cfg.stay_on_ticks;
      end
      dmit_pkg::OP_MOTOR_OFF: begin
        st_nxt.motor_running = 1'b0;
        st_nxt.off_elapsed   = '0;
      end
      dmit_pkg::OP_CTRL_RST: begin
        st_nxt.motor_running = 1'b0;
      end
      default: begin
        // unused codes leave everything as is
      end
    endcase
  end

  assign res.motor_a_on      = st_nxt.motor_running && !st_nxt.motor_drive;
  assign res.motor_b_on      = st_nxt.motor_running && st_nxt.motor_drive;
  assign res.selected_drive  = st_nxt.motor_drive;
  assign res.spin_wait_ticks = wait_ticks;
  assign res.running         = st_nxt.motor_running;

endmodule

/* hdl/drive_motor_idle_timer.sv */
// Drive motor idle timer: top level with input, state and result registers.
// Path: an accepted request waits in the input register and moves on, with its
//   result, into the result register, which drives the output channel.
// Throughput: one request per cycle while the output is not stalled; the state update
//   (one add/compare/subtract on the 16-bit counters in dmit_step) is combinational.
// Stalls: a held result does not block intake while the input register is free.
// Reset: rst_n is synchronous, active low; it clears the pipeline valids and the
//   motor state and loads the default configuration.
module drive_motor_idle_timer (
  input  logic       clk,
  input  logic       rst_n,
  dmit_in_if.sink    in_chan,
  dmit_out_if.source out_chan,
  dmit_cfg_if.sink   cfg_chan
);

  // plain copies of the handshake and result ports; the output ones are seen by the checker
  logic                        in_valid;
  logic                        in_ready;
  logic                        out_valid;
  logic                        out_ready;
  logic                        out_motor_a_on;
  logic                        out_motor_b_on;
  logic                        out_selected_drive;
  logic [dmit_pkg::TICK_W-1:0] out_spin_wait_ticks;
  logic                        out_running;

  // configuration registers
  dmit_pkg::cfg_t    cfg_r;

  // motor state
  dmit_pkg::state_t  st_r;
  dmit_pkg::state_t  st_nxt;

  // input register stage
  logic              s1_valid_r;
  dmit_pkg::item_t   s1_item_r;

  // result register stage
  logic              out_valid_r;
  dmit_pkg::result_t res_r;
  dmit_pkg::result_t res_nxt;

  logic              s1_go;
  logic              in_take;

  assign in_valid  = in_chan.valid;
  assign out_ready = out_chan.ready;

  // stage 1 hands its request on when the result register is empty or draining
  assign s1_go    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;
  assign in_take  = in_valid && in_ready;

  assign in_chan.ready  = in_ready;
  assign cfg_chan.ready = 1'b1;

  // config writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stay_on_ticks <= dmit_pkg::STAY_ON_RST;
      cfg_r.coast_ticks   <= dmit_pkg::COAST_RST;
      cfg_r.spin_up_ticks <= dmit_pkg::SPIN_UP_RST;
      cfg_r.skip_delays   <= 1'b0;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        dmit_pkg::CFG_STAY_ON_TICKS: cfg_r.stay_on_ticks <= cfg_chan.data;
        dmit_pkg::CFG_COAST_TICKS:   cfg_r.coast_ticks   <= cfg_chan.data;
        dmit_pkg::CFG_SPIN_UP_TICKS: cfg_r.spin_up_ticks <= cfg_chan.data;
        dmit_pkg::CFG_SKIP_DELAYS:   cfg_r.skip_delays   <= cfg_chan.data[0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.operation     <= in_chan.operation;
      s1_item_r.drive         <= in_chan.drive;
      s1_item_r.elapsed_ticks <= in_chan.elapsed_ticks;
    end
  end

  dmit_step u_step (
    .cfg    (cfg_r),
    .st     (st_r),
    .item   (s1_item_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // state commits exactly when the request moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (s1_go) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_motor_a_on      = res_r.motor_a_on;
  assign out_motor_b_on      = res_r.motor_b_on;
  assign out_selected_drive  = res_r.selected_drive;
  assign out_spin_wait_ticks = res_r.spin_wait_ticks;
  assign out_running         = res_r.running;

  assign out_chan.valid           = out_valid;
  assign out_chan.motor_a_on      = out_motor_a_on;
  assign out_chan.motor_b_on      = out_motor_b_on;
  assign out_chan.selected_drive  = out_selected_drive;
  assign out_chan.spin_wait_ticks = out_spin_wait_ticks;
  assign out_chan.running         = out_running;

endmodule

/* hdl/dmit_checker.sv */
// Port-level checks for the drive motor idle timer, bound to the top level.
module dmit_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_motor_a_on,
  input logic        out_motor_b_on,
  input logic        out_selected_drive,
  input logic [15:0] out_spin_wait_ticks,
  input logic        out_running
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_spin_wait_ticks)
      && $stable(out_running) && $stable(out_selected_drive))
    else $error("result changed while stalled");

  // no result right after reset
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // enables agree with running flag and selected drive
  a_enables: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_running == (out_motor_a_on || out_motor_b_on))
      && !(out_motor_a_on && out_motor_b_on)
      && (!out_motor_a_on || !out_selected_drive)
      && (!out_motor_b_on || out_selected_drive))
    else $error("motor enables inconsistent");

  // a spin-up wait is only reported with the motor running
  a_wait_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_spin_wait_ticks != 16'd0) |-> out_running)
    else $error("spin wait without running motor");

endmodule

bind drive_motor_idle_timer dmit_checker u_dmit_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_motor_a_on      (out_motor_a_on),
  .out_motor_b_on      (out_motor_b_on),
  .out_selected_drive  (out_selected_drive),
  .out_spin_wait_ticks (out_spin_wait_ticks),
  .out_running         (out_running)
);
